### design/bfpc_pkg.sv
package bfpc_pkg;

   // field widths
   localparam int unsigned POS_W   = 32;
   localparam int unsigned QUAT_W  = 16;
   localparam int unsigned GAIN_W  = 48;
   localparam int unsigned LANE_W  = 16;
   localparam int unsigned LIM_W   = 31;
   localparam int unsigned ADDR_W  = 2;

   // shared multiplier operand widths (b holds sin/cos up to 24 fraction bits)
   localparam int unsigned MUL_A_W = 40;
   localparam int unsigned MUL_B_W = 26;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   // sequencer fields
   localparam int unsigned STEP_W  = 5;
   localparam int unsigned ITER_W  = 5;
   localparam int unsigned AXIS_W  = 2;

   // event kinds
   localparam logic [1:0] OP_REF  = 2'd0;
   localparam logic [1:0] OP_ODOM = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // register indexes
   localparam logic [ADDR_W-1:0] REG_P_GAINS   = 2'd0;
   localparam logic [ADDR_W-1:0] REG_I_GAINS   = 2'd1;
   localparam logic [ADDR_W-1:0] REG_D_GAINS   = 2'd2;
   localparam logic [ADDR_W-1:0] REG_VEL_LIMIT = 2'd3;

   // register reset values
   localparam logic [GAIN_W-1:0] P_GAINS_RST   = 48'd21110032699392;
   localparam logic [GAIN_W-1:0] I_GAINS_RST   = 48'd3517605085594;
   localparam logic [GAIN_W-1:0] D_GAINS_RST   = 48'd10557163833344;
   localparam logic [LIM_W-1:0]  VEL_LIMIT_RST = 31'd65536;

   // cordic gain compensation, 2^30 scale
   localparam logic signed [35:0] CORDIC_K = 36'sd652032874;

   // floor(y/25) estimate: (y * DIV25_M) >> DIV25_SH, low by at most one
   localparam logic [24:0] DIV25_M  = 25'd21474836;
   localparam int unsigned DIV25_SH = 29;

   // sequencer steps
   localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] ST_Q_WZ     = 5'd1;
   localparam logic [STEP_W-1:0] ST_Q_XY     = 5'd2;
   localparam logic [STEP_W-1:0] ST_Q_YY     = 5'd3;
   localparam logic [STEP_W-1:0] ST_Q_ZZ     = 5'd4;
   localparam logic [STEP_W-1:0] ST_YAW_INIT = 5'd5;
   localparam logic [STEP_W-1:0] ST_YAW_ITER = 5'd6;
   localparam logic [STEP_W-1:0] ST_YAW_DONE = 5'd7;
   localparam logic [STEP_W-1:0] ST_SC_INIT  = 5'd8;
   localparam logic [STEP_W-1:0] ST_SC_ITER  = 5'd9;
   localparam logic [STEP_W-1:0] ST_SC_DONE  = 5'd10;
   localparam logic [STEP_W-1:0] ST_ROT0     = 5'd11;
   localparam logic [STEP_W-1:0] ST_ROT1     = 5'd12;
   localparam logic [STEP_W-1:0] ST_ROT2     = 5'd13;
   localparam logic [STEP_W-1:0] ST_ROT3     = 5'd14;
   localparam logic [STEP_W-1:0] ST_ROT4     = 5'd15;
   localparam logic [STEP_W-1:0] ST_AX_DIV   = 5'd16;
   localparam logic [STEP_W-1:0] ST_AX_QUO   = 5'd17;
   localparam logic [STEP_W-1:0] ST_AX_REM   = 5'd18;
   localparam logic [STEP_W-1:0] ST_AX_INT   = 5'd19;
   localparam logic [STEP_W-1:0] ST_AX_MIH   = 5'd20;
   localparam logic [STEP_W-1:0] ST_AX_MIL   = 5'd21;
   localparam logic [STEP_W-1:0] ST_AX_MD    = 5'd22;
   localparam logic [STEP_W-1:0] ST_AX_SUM   = 5'd23;
   localparam logic [STEP_W-1:0] ST_EMIT     = 5'd24;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic signed [POS_W-1:0] vel_x;
      logic signed [POS_W-1:0] vel_y;
      logic signed [POS_W-1:0] vel_z;
      logic [2:0]              clamped_axes;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [ITER_W-1:0] iter;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage

### design/bfpc_ctrl.sv
module bfpc_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            op,
   input  logic                  target_seen,
   input  logic                  rsp_free,
   output bfpc_pkg::cmd_type     cmd,
   output logic                  idle,
   output logic                  emit
);
   import bfpc_pkg::*;

   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

   logic [STEP_W-1:0] state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_ODOM: state_in = ST_Q_WZ;
                  OP_TICK: state_in = target_seen ? ST_SC_INIT : ST_EMIT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_Q_WZ:     state_in = ST_Q_XY;
         ST_Q_XY:     state_in = ST_Q_YY;
         ST_Q_YY:     state_in = ST_Q_ZZ;
         ST_Q_ZZ:     state_in = ST_YAW_INIT;
         ST_YAW_INIT: begin
            state_in = ST_YAW_ITER;
            iter_in  = '0;
         end
         ST_YAW_ITER: begin
            if (iter_ff == LAST_ITER) begin
               state_in = ST_YAW_DONE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_YAW_DONE: state_in = ST_IDLE;
         ST_SC_INIT: begin
            state_in = ST_SC_ITER;
            iter_in  = '0;
         end
         ST_SC_ITER: begin
            if (iter_ff == LAST_ITER) begin
               state_in = ST_SC_DONE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_SC_DONE: state_in = ST_ROT0;
         ST_ROT0:    state_in = ST_ROT1;
         ST_ROT1:    state_in = ST_ROT2;
         ST_ROT2:    state_in = ST_ROT3;
         ST_ROT3:    state_in = ST_ROT4;
         ST_ROT4: begin
            state_in = ST_AX_DIV;
            axis_in  = '0;
         end
         ST_AX_DIV:  state_in = ST_AX_QUO;
         ST_AX_QUO:  state_in = ST_AX_REM;
         ST_AX_REM:  state_in = ST_AX_INT;
         ST_AX_INT:  state_in = ST_AX_MIH;
         ST_AX_MIH:  state_in = ST_AX_MIL;
         ST_AX_MIL:  state_in = ST_AX_MD;
         ST_AX_MD:   state_in = ST_AX_SUM;
         ST_AX_SUM: begin
            if (axis_ff == AXIS_W'(2)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_AX_DIV;
               axis_in  = axis_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         axis_ff  <= axis_in;
      end
   end

   // commands to the datapath
   assign cmd.step = state_ff;
   assign cmd.iter = iter_ff;
   assign cmd.axis = axis_ff;
   assign idle     = (state_ff == ST_IDLE);
   assign emit     = (state_ff == ST_EMIT) && rsp_free;

endmodule

### design/bfpc_dp.sv
module bfpc_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bfpc_pkg::cmd_type                     cmd,
   input  logic                                  accept,
   input  bfpc_pkg::req_type                     req,
   input  logic                                  csr_we,
   input  logic [bfpc_pkg::ADDR_W-1:0]           csr_addr,
   input  logic [bfpc_pkg::GAIN_W-1:0]           csr_wdata,
   output logic                                  target_seen,
   output bfpc_pkg::rsp_type                     result
);
   import bfpc_pkg::*;

   // configuration
   logic [GAIN_W-1:0] p_gains_ff, i_gains_ff, d_gains_ff;
   logic [LIM_W-1:0]  vel_limit_ff;

   // architectural state
   logic signed [31:0] tgt_ff  [3];
   logic signed [31:0] meas_ff [3];
   logic signed [47:0] int_ff  [3];
   logic signed [31:0] prev_ff [3];
   logic [15:0]        heading_ff;
   logic               seen_ff;

   // working registers
   logic signed [15:0]        qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [32:0]        e_ff  [3];
   logic signed [31:0]        eb_ff [3];
   logic signed [35:0]        cx_ff, cy_ff, s_ff;
   logic signed [33:0]        ang_ff;
   logic                      zero_ff, flip_ff, neg_ff;
   logic signed [MUL_B_W-1:0] cs_ff, sn_ff;
   logic signed [MUL_P_W-1:0] prod_ff, t0_ff;
   logic [31:0]               y_ff;
   logic [26:0]               q_ff;
   logic signed [39:0]        de_ff;
   logic signed [63:0]        acc_ff;
   logic signed [31:0]        vel_ff [3];
   logic [2:0]                flags_ff;
   logic                      wait_ff;

   // sin/cos scaling into FRAC_BITS with saturation to +-1
   function automatic logic signed [MUL_B_W-1:0] to_frac(input logic signed [35:0] v,
                                                         input logic neg);
      logic signed [35:0] one;
      logic signed [35:0] r;
      one = 36'sd1 <<< FRAC_BITS;
      r = (v + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (r > one) begin
         r = one;
      end else if (r < -one) begin
         r = -one;
      end
      if (neg) begin
         r = -r;
      end
      return MUL_B_W'(r);
   endfunction

   function automatic logic [LANE_W-1:0] lane(input logic [GAIN_W-1:0] g,
                                              input logic [AXIS_W-1:0] k);
      logic [LANE_W-1:0] l;
      case (k)
         2'd0:    l = g[15:0];
         2'd1:    l = g[31:16];
         default: l = g[47:32];
      endcase
      return l;
   endfunction

   // per-axis selections
   logic [AXIS_W-1:0]  k;
   logic signed [31:0] eb_k, prev_k;
   logic signed [47:0] int_k;
   assign k      = cmd.axis;
   assign eb_k   = eb_ff[k];
   assign prev_k = prev_ff[k];
   assign int_k  = int_ff[k];

   // shared multiplier, registered every cycle
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_in;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_Q_WZ: begin
            mul_a = MUL_A_W'(qw_ff);
            mul_b = MUL_B_W'(qz_ff);
         end
         ST_Q_XY: begin
            mul_a = MUL_A_W'(qx_ff);
            mul_b = MUL_B_W'(qy_ff);
         end
         ST_Q_YY: begin
            mul_a = MUL_A_W'(qy_ff);
            mul_b = MUL_B_W'(qy_ff);
         end
         ST_Q_ZZ: begin
            mul_a = MUL_A_W'(qz_ff);
            mul_b = MUL_B_W'(qz_ff);
         end
         ST_ROT0: begin
            mul_a = MUL_A_W'(e_ff[0]);
            mul_b = cs_ff;
         end
         ST_ROT1: begin
            mul_a = MUL_A_W'(e_ff[1]);
            mul_b = sn_ff;
         end
         ST_ROT2: begin
            mul_a = MUL_A_W'(e_ff[1]);
            mul_b = cs_ff;
         end
         ST_ROT3: begin
            mul_a = MUL_A_W'(e_ff[0]);
            mul_b = sn_ff;
         end
         ST_AX_QUO: begin
            mul_a = MUL_A_W'(y_ff);
            mul_b = MUL_B_W'(DIV25_M);
         end
         ST_AX_REM: begin
            mul_a = MUL_A_W'(eb_k);
            mul_b = MUL_B_W'(lane(p_gains_ff, k));
         end
         ST_AX_MIH: begin
            mul_a = MUL_A_W'(signed'(int_k[47:24]));
            mul_b = MUL_B_W'(lane(i_gains_ff, k));
         end
         ST_AX_MIL: begin
            mul_a = MUL_A_W'(int_k[23:0]);
            mul_b = MUL_B_W'(lane(i_gains_ff, k));
         end
         ST_AX_MD: begin
            mul_a = de_ff;
            mul_b = MUL_B_W'(lane(d_gains_ff, k));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // quaternion terms for the atan2 operands
   logic signed [35:0] quad_sum, s_in, c_in;
   assign quad_sum = signed'(t0_ff[35:0]) + signed'(prod_ff[35:0]);
   assign s_in     = quad_sum <<< 1;
   assign c_in     = 36'sd268435456 - (quad_sum <<< 1);

   // cordic step shared by vectoring and rotation
   logic signed [35:0] dx, dy;
   logic signed [33:0] atan_i;
   logic               rot_up;
   assign dx     = cy_ff >>> cmd.iter;
   assign dy     = cx_ff >>> cmd.iter;
   assign atan_i = signed'({2'b00, atan_turn(cmd.iter)});
   assign rot_up = (cmd.step == ST_YAW_ITER) ? !cy_ff[35] : ang_ff[33];

   logic [31:0] heading_rnd;
   assign heading_rnd = ang_ff[31:0] + 32'h0000_8000;

   // sine/cosine start angle, folded into quadrants 0 and 3
   logic [31:0] turn;
   logic        fold;
   assign turn = {heading_ff, 16'h0000};
   assign fold = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);

   // rotated error, rounded and saturated
   logic signed [66:0] rot_sum, rot_shift;
   logic signed [31:0] eb_rot, eb_z;
   always_comb begin
      if (cmd.step == ST_ROT4) begin
         rot_sum = 67'(t0_ff) - 67'(prod_ff);
      end else begin
         rot_sum = 67'(t0_ff) + 67'(prod_ff);
      end
      rot_sum   = rot_sum + (67'sd1 <<< (FRAC_BITS - 1));
      rot_shift = rot_sum >>> FRAC_BITS;
      if (rot_shift > 67'sd2147483647) begin
         eb_rot = 32'sh7FFF_FFFF;
      end else if (rot_shift < -67'sd2147483648) begin
         eb_rot = 32'sh8000_0000;
      end else begin
         eb_rot = rot_shift[31:0];
      end
      if (e_ff[2] > 33'sd2147483647) begin
         eb_z = 32'sh7FFF_FFFF;
      end else if (e_ff[2] < -33'sd2147483648) begin
         eb_z = 32'sh8000_0000;
      end else begin
         eb_z = e_ff[2][31:0];
      end
   end

   // integral step prep and derivative
   logic signed [32:0] eb_x, diff;
   logic [32:0]        mag, mag_rnd;
   logic [31:0]        y_in;
   logic signed [39:0] de_in;
   assign eb_x    = 33'(eb_k);
   assign mag     = eb_x[32] ? 33'(-eb_x) : 33'(eb_x);
   assign mag_rnd = mag + 33'd25;
   assign y_in    = mag_rnd[32:1];
   assign diff    = eb_x - 33'(prev_k);
   assign de_in   = (40'(diff) <<< 5) + (40'(diff) <<< 4) + (40'(diff) <<< 1);

   // quotient correction and integral update
   logic [26:0]        q_in, q_fix;
   logic [31:0]        q25, rem;
   logic signed [27:0] step_v;
   logic signed [48:0] int_sum;
   logic signed [47:0] int_in;
   assign q_in = prod_ff[DIV25_SH+26:DIV25_SH];
   always_comb begin
      q25    = 32'({q_ff, 4'b0000}) + 32'({q_ff, 3'b000}) + 32'(q_ff);
      rem    = y_ff - q25;
      q_fix  = (rem >= 32'd25) ? q_ff + 27'd1 : q_ff;
      step_v = neg_ff ? -signed'({1'b0, q_fix}) : signed'({1'b0, q_fix});
      int_sum = 49'(int_k) + 49'(step_v);
      if (int_sum > ((49'sd1 <<< 47) - 49'sd1)) begin
         int_in = 48'sh7FFF_FFFF_FFFF;
      end else if (int_sum < -(49'sd1 <<< 47)) begin
         int_in = 48'sh8000_0000_0000;
      end else begin
         int_in = int_sum[47:0];
      end
   end

   // integral term from its two partial products, capped
   logic signed [64:0] it_raw;
   logic signed [63:0] it_cap;
   always_comb begin
      it_raw = (65'(signed'(t0_ff[40:0])) <<< 24) + 65'(prod_ff);
      if (it_raw > (65'sd1 <<< 60)) begin
         it_cap = 64'sd1 <<< 60;
      end else if (it_raw < -(65'sd1 <<< 60)) begin
         it_cap = -(64'sd1 <<< 60);
      end else begin
         it_cap = it_raw[63:0];
      end
   end

   // final sum, rounding and clamp
   logic signed [63:0] total, v, lim;
   logic signed [31:0] vel_in;
   logic               clamp_in;
   always_comb begin
      total    = acc_ff + signed'(prod_ff[63:0]) + 64'sd2048;
      v        = total >>> 12;
      lim      = 64'(signed'({1'b0, vel_limit_ff}));
      clamp_in = 1'b1;
      if (v > lim) begin
         vel_in = lim[31:0];
      end else if (v < -lim) begin
         vel_in = 32'(-lim);
      end else begin
         vel_in   = v[31:0];
         clamp_in = 1'b0;
      end
   end

   // configuration and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gains_ff   <= P_GAINS_RST;
         i_gains_ff   <= I_GAINS_RST;
         d_gains_ff   <= D_GAINS_RST;
         vel_limit_ff <= VEL_LIMIT_RST;
         heading_ff   <= '0;
         seen_ff      <= 1'b0;
         for (int n = 0; n < 3; n++) begin
            tgt_ff[n]  <= '0;
            meas_ff[n] <= '0;
            int_ff[n]  <= '0;
            prev_ff[n] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_P_GAINS:   p_gains_ff   <= csr_wdata;
               REG_I_GAINS:   i_gains_ff   <= csr_wdata;
               REG_D_GAINS:   d_gains_ff   <= csr_wdata;
               REG_VEL_LIMIT: vel_limit_ff <= csr_wdata[LIM_W-1:0];
               default:       vel_limit_ff <= vel_limit_ff;
            endcase
         end
         if (accept) begin
            case (req.op)
               OP_REF: begin
                  tgt_ff[0] <= req.pos_x;
                  tgt_ff[1] <= req.pos_y;
                  tgt_ff[2] <= req.pos_z;
                  seen_ff   <= 1'b1;
               end
               OP_ODOM: begin
                  meas_ff[0] <= req.pos_x;
                  meas_ff[1] <= req.pos_y;
                  meas_ff[2] <= req.pos_z;
               end
               default: seen_ff <= seen_ff;
            endcase
         end
         if (cmd.step == ST_YAW_DONE) begin
            heading_ff <= zero_ff ? 16'h0000 : heading_rnd[31:16];
         end
         if (cmd.step == ST_AX_INT) begin
            int_ff[k] <= int_in;
         end
         if (cmd.step == ST_AX_SUM) begin
            prev_ff[k] <= eb_k;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept && (req.op == OP_ODOM)) begin
         qw_ff <= req.quat_w;
         qx_ff <= req.quat_x;
         qy_ff <= req.quat_y;
         qz_ff <= req.quat_z;
      end
      if (accept && (req.op == OP_TICK)) begin
         wait_ff   <= !seen_ff;
         flags_ff  <= '0;
         vel_ff[0] <= '0;
         vel_ff[1] <= '0;
         vel_ff[2] <= '0;
      end
      unique case (cmd.step)
         ST_Q_XY, ST_Q_ZZ, ST_ROT1, ST_ROT3, ST_AX_MIL: begin
            t0_ff <= prod_ff;
         end
         ST_Q_YY: begin
            s_ff <= s_in;
         end
         ST_YAW_INIT: begin
            zero_ff <= (s_ff == 36'sd0) && (c_in == 36'sd0);
            if (c_in < 36'sd0) begin
               cx_ff  <= -c_in;
               cy_ff  <= -s_ff;
               ang_ff <= 34'sh0_8000_0000;
            end else begin
               cx_ff  <= c_in;
               cy_ff  <= s_ff;
               ang_ff <= '0;
            end
         end
         ST_YAW_ITER, ST_SC_ITER: begin
            if (rot_up) begin
               cx_ff  <= cx_ff + dx;
               cy_ff  <= cy_ff - dy;
               ang_ff <= ang_ff + atan_i;
            end else begin
               cx_ff  <= cx_ff - dx;
               cy_ff  <= cy_ff + dy;
               ang_ff <= ang_ff - atan_i;
            end
         end
         ST_SC_INIT: begin
            cx_ff   <= CORDIC_K;
            cy_ff   <= '0;
            flip_ff <= fold;
            ang_ff  <= 34'(signed'(fold ? turn ^ 32'h8000_0000 : turn));
            for (int n = 0; n < 3; n++) begin
               e_ff[n] <= 33'(tgt_ff[n]) - 33'(meas_ff[n]);
            end
         end
         ST_SC_DONE: begin
            cs_ff <= to_frac(cx_ff, flip_ff);
            sn_ff <= to_frac(cy_ff, flip_ff);
         end
         ST_ROT2: begin
            eb_ff[0] <= eb_rot;
         end
         ST_ROT4: begin
            eb_ff[1] <= eb_rot;
            eb_ff[2] <= eb_z;
         end
         ST_AX_DIV: begin
            y_ff   <= y_in;
            de_ff  <= de_in;
            neg_ff <= eb_x[32];
         end
         ST_AX_REM: begin
            q_ff <= q_in;
         end
         ST_AX_INT: begin
            acc_ff <= signed'(prod_ff[63:0]);
         end
         ST_AX_MD: begin
            acc_ff <= acc_ff + it_cap;
         end
         ST_AX_SUM: begin
            vel_ff[k]   <= vel_in;
            flags_ff[k] <= clamp_in;
         end
         default: begin
            t0_ff <= t0_ff;
         end
      endcase
   end

   assign target_seen         = seen_ff;
   assign result.status       = wait_ff;
   assign result.vel_x        = vel_ff[0];
   assign result.vel_y        = vel_ff[1];
   assign result.vel_z        = vel_ff[2];
   assign result.clamped_axes = flags_ff;

endmodule

### design/body_frame_pid_position_controller.sv
// Body-frame three-axis PID position controller.
// req channel (valid/ready) carries one event per item: op 0 stores the
// target position, op 1 stores the measured position and quaternion yaw,
// op 2 is a 20 ms control tick; op 3 is dropped. Only ticks give a result
// item on the rsp channel (valid/ready): the velocity command, clamp flags
// and a waiting status when no target has been stored yet.
// Timing: a reference or unused event is absorbed in the cycle it arrives.
// An odometry event holds the sequencer for four quaternion products and
// one vectoring pass. A tick takes one sine/cosine pass, four rotation
// products, then per axis the P, I and D terms on the single shared 40x26
// multiplier, which sets the rate; a tick before any target skips to the
// last step. One item is in work at a time.
// The result sits in an output register; if rsp_ready is low the next event
// is still taken, and a following tick waits at its last step until the
// register is free. csr writes set gains and the limit; the user is to
// write them only while idle, which the block itself does not enforce.
// Synchronous reset restores register defaults and clears the positions,
// integrals, previous errors, heading, sequencer and output valid.
module body_frame_pid_position_controller #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bfpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bfpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [bfpc_pkg::ADDR_W-1:0]       csr_addr,
   input  logic [bfpc_pkg::GAIN_W-1:0]       csr_wdata
);
   import bfpc_pkg::*;

   cmd_type cmd;
   rsp_type result;
   logic    accept, idle, emit, target_seen, rsp_free;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign req_ready = idle;
   assign accept    = req_valid && idle;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   bfpc_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_data.op),
      .target_seen (target_seen),
      .rsp_free    (rsp_free),
      .cmd         (cmd),
      .idle        (idle),
      .emit        (emit)
   );

   bfpc_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .accept      (accept),
      .req         (req_data),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .target_seen (target_seen),
      .result      (result)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bfpc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [ADDR_W-1:0]   csr_addr = REG_P_GAINS;
   logic [GAIN_W-1:0]   csr_wdata = '0;

   body_frame_pid_position_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // atan(2^-i) in 2^-32 turn
   localparam logic [31:0] ATAN_TURN [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };
   localparam longint I32_LO = -64'sd2147483648;
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint I48_LO = -(64'sd1 <<< 47);
   localparam longint I48_HI = (64'sd1 <<< 47) - 1;
   localparam longint TERM_CAP = 64'sd1 <<< 60;

   // controller copy: gains, limit and state
   logic [GAIN_W-1:0] kp = P_GAINS_RST, ki = I_GAINS_RST, kd = D_GAINS_RST;
   logic [LIM_W-1:0]  vlim = VEL_LIMIT_RST;
   longint            tgt [3] = '{0, 0, 0};
   longint            meas [3] = '{0, 0, 0};
   longint            integ [3] = '{0, 0, 0};
   longint            prev_err [3] = '{0, 0, 0};
   logic [15:0]       heading = '0;
   logic              tgt_seen = 1'b0;

   req_type pending_items [$];
   rsp_type expected_cmds [$];
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_left = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // heading from quaternion by cordic vectoring
   function automatic logic [15:0] quat_heading(longint w, longint x, longint y, longint z);
      longint      s, c, vx, vy, dx, dy;
      logic [31:0] ang;
      s = 2 * (w * z + x * y);
      c = (64'sd1 <<< 28) - 2 * (y * y + z * z);
      vx = c;
      vy = s;
      ang = '0;
      if (s == 0 && c == 0) return '0;
      if (c < 0) begin
         vx = -c;
         vy = -s;
         ang = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy < 0) begin
            vx -= dx; vy += dy; ang -= ATAN_TURN[i];
         end else begin
            vx += dx; vy -= dy; ang += ATAN_TURN[i];
         end
      end
      ang = ang + 32'h8000;
      return ang[31:16];
   endfunction

   function automatic longint round_unit(longint v, logic neg);
      longint r;
      r = clip((v + (64'sd1 <<< 13)) >>> 14, -65536, 65536);
      return neg ? -r : r;
   endfunction

   // sine and cosine of the heading
   task automatic heading_sin_cos(input logic [15:0] h, output longint cs, output longint sn);
      logic [31:0] t;
      logic        neg;
      longint      z, x, y, dx, dy;
      t = {h, 16'h0};
      neg = 1'b0;
      x = 652032874;
      y = 0;
      if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
         t -= 32'h80000000;
         neg = 1'b1;
      end
      z = longint'(signed'(t));
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
         end
      end
      cs = round_unit(x, neg);
      sn = round_unit(y, neg);
   endtask

   // one event into the controller copy; ticks queue a velocity command
   task automatic apply_event(input req_type it);
      longint  e [3], eb [3], cs, sn, de, mag, stp, pt, itm, dt, v, lim;
      rsp_type cmd;
      cmd = '0;
      case (it.op)
         OP_REF: begin
            tgt[0] = it.pos_x; tgt[1] = it.pos_y; tgt[2] = it.pos_z;
            tgt_seen = 1'b1;
         end
         OP_ODOM: begin
            meas[0] = it.pos_x; meas[1] = it.pos_y; meas[2] = it.pos_z;
            heading = quat_heading(it.quat_w, it.quat_x, it.quat_y, it.quat_z);
         end
         OP_TICK: begin
            if (!tgt_seen) begin
               cmd.status = 1'b1;
            end else begin
               for (int k = 0; k < 3; k++) e[k] = tgt[k] - meas[k];
               heading_sin_cos(heading, cs, sn);
               eb[0] = clip((cs * e[0] + sn * e[1] + 32768) >>> 16, I32_LO, I32_HI);
               eb[1] = clip((cs * e[1] - sn * e[0] + 32768) >>> 16, I32_LO, I32_HI);
               eb[2] = clip(e[2], I32_LO, I32_HI);
               lim = longint'(vlim);
               for (int k = 0; k < 3; k++) begin
                  de = (eb[k] - prev_err[k]) * 50;
                  mag = eb[k] < 0 ? -eb[k] : eb[k];
                  stp = (2 * mag + 50) / 100;
                  if (eb[k] < 0) stp = -stp;
                  integ[k] = clip(integ[k] + stp, I48_LO, I48_HI);
                  pt = clip(longint'(kp[k*16 +: 16]) * eb[k], -TERM_CAP, TERM_CAP);
                  itm = clip(longint'(ki[k*16 +: 16]) * integ[k], -TERM_CAP, TERM_CAP);
                  dt = clip(longint'(kd[k*16 +: 16]) * de, -TERM_CAP, TERM_CAP);
                  v = (pt + itm + dt + 2048) >>> 12;
                  if (v > lim) begin
                     v = lim;
                     cmd.clamped_axes[k] = 1'b1;
                  end else if (v < -lim) begin
                     v = -lim;
                     cmd.clamped_axes[k] = 1'b1;
                  end
                  case (k)
                     0: cmd.vel_x = v[31:0];
                     1: cmd.vel_y = v[31:0];
                     default: cmd.vel_z = v[31:0];
                  endcase
                  prev_err[k] = eb[k];
               end
            end
            expected_cmds.push_back(cmd);
         end
         default: ;
      endcase
   endtask

   // driver: offer pending items, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_event(req_data);
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check velocity commands, random and long receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected command %p", rsp_data);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_data.status !== want.status || rsp_data.vel_x !== want.vel_x ||
                   rsp_data.vel_y !== want.vel_y || rsp_data.vel_z !== want.vel_z ||
                   rsp_data.clamped_axes !== want.clamped_axes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("command mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   function automatic req_type make_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [15:0] qw, logic [15:0] qx,
                                         logic [15:0] qy, logic [15:0] qz);
      req_type it;
      it.op = op;
      it.pos_x = px; it.pos_y = py; it.pos_z = pz;
      it.quat_w = qw; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz;
      return it;
   endfunction

   // position near the origin most of the time, full range otherwise
   function automatic logic [31:0] rand_pos();
      if ($urandom_range(9) < 7) return $urandom_range(0, 524288) - 262144;
      return $urandom;
   endfunction

   function automatic req_type rand_item(logic [1:0] op);
      return make_item(op, rand_pos(), rand_pos(), rand_pos(), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   task automatic csr_write(input logic [ADDR_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_P_GAINS: kp = val;
         REG_I_GAINS: ki = val;
         REG_D_GAINS: kd = val;
         default:     vlim = val[LIM_W-1:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_cmds.size() > 0)
         @(posedge clock);
   endtask

   // well-formed control runs plus some noise
   task automatic queue_random(input int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) < 8) begin
            pending_items.push_back(rand_item(OP_REF));
            pending_items.push_back(rand_item(OP_ODOM));
            n += 2;
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(4) == 0) begin
                  pending_items.push_back(rand_item(OP_ODOM));
                  n++;
               end
               pending_items.push_back(rand_item(OP_TICK));
               n++;
            end
         end else begin
            pending_items.push_back(rand_item(2'($urandom_range(3))));
            n++;
         end
      end
   endtask

   // stimulus in phases of register settings and idling patterns
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: waiting tick, unused op, extremes, special headings
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(2'd3, '1, '1, '1, '1, '1, '1, '1));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_REF, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_REF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        0, 0, 0, 0));
      pending_items.push_back(make_item(OP_ODOM, 32'h80000000, 32'h80000000, 32'h80000000,
                                        16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_ODOM, 65536, -65536, 0,
                                        16'd100, -16'sd100, 16'd8192, 16'd8192));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_ODOM, 0, 0, 0, 0, 0, 0, 16'd16384));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_REF, 32'h80000000, 32'h80000000, 32'h80000000,
                                        0, 0, 0, 0));
      pending_items.push_back(make_item(OP_ODOM, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        16'h8000, 16'h8000, 16'h8000, 16'h8000));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_ODOM, 0, 0, 0, 16'd16384, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();
      repeat (80) @(posedge clock);

      for (int ph = 0; ph < 6; ph++) begin
         // registers while idle: defaults kept first, then extremes, random, and default gains with a raised limit
         case (ph)
            1: begin
               csr_write(REG_P_GAINS, '1); csr_write(REG_I_GAINS, '1);
               csr_write(REG_D_GAINS, '1); csr_write(REG_VEL_LIMIT, 48'h7FFFFFFF);
            end
            2: begin
               csr_write(REG_P_GAINS, '0); csr_write(REG_I_GAINS, '0);
               csr_write(REG_D_GAINS, '0); csr_write(REG_VEL_LIMIT, '0);
            end
            3, 4: begin
               csr_write(REG_P_GAINS, 48'({$urandom, $urandom}));
               csr_write(REG_I_GAINS, 48'({$urandom, $urandom}));
               csr_write(REG_D_GAINS, 48'({$urandom, $urandom}));
               csr_write(REG_VEL_LIMIT, 48'($urandom_range(0, 32'h7FFFFFFF)));
            end
            5: begin
               csr_write(REG_P_GAINS, P_GAINS_RST); csr_write(REG_I_GAINS, I_GAINS_RST);
               csr_write(REG_D_GAINS, D_GAINS_RST);
               csr_write(REG_VEL_LIMIT, 48'd1000000);
            end
            default: ;
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         // long receiver hold while items keep coming
         if (ph == 0) hold_left = 600;
         queue_random(100);
         // sender pause until all commands are back
         wait_drained();
         queue_random(110);
         wait_drained();
         repeat (80) @(posedge clock);
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("body_frame_pid_position_controller regression: pass");
      end else begin
         $display("body_frame_pid_position_controller regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("body_frame_pid_position_controller regression: fail");
      $finish;
   end

endmodule

### body_frame_pid_position_controller.f
design/bfpc_pkg.sv
design/bfpc_ctrl.sv
design/bfpc_dp.sv
design/body_frame_pid_position_controller.sv
verif/tb_top.sv
